// ===== sv/eka_pkg.sv =====
// shared types and constants for the edmonds-karp max flow core
package eka_pkg;

    localparam int ACTW = 2;
    localparam int NODEW = 8;
    localparam int CAPW = 30;
    localparam int FLOWW = 48;

    localparam logic [ACTW-1:0] ACT_CLEAR = 2'd0;
    localparam logic [ACTW-1:0] ACT_EDGE = 2'd1;
    localparam logic [ACTW-1:0] ACT_COMPUTE = 2'd2;

    // starting bottleneck of every search; a path bottleneck never exceeds it
    localparam logic [CAPW-1:0] BN_START = 30'd1000000007;
    localparam logic [FLOWW-1:0] FLOW_MAX = {FLOWW{1'b1}};

    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_EDGE_RMW,
        S_EDGE_WR,
        S_SRCH,
        S_DEQ,
        S_DEQW,
        S_SCAN,
        S_APAR,
        S_APARW,
        S_AFWD,
        S_AREV,
        S_DONE
    } t_state;

endpackage

// ===== sv/eka_ram.sv =====
// generic simple dual port ram with registered read
module eka_ram
    #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/max_flow_edmonds_karp_core.sv =====
// edmonds-karp max flow core: graph memory, bfs sequencer and path augmentation
//
// channel   dir  width  fields (low bit up)
// s (input) in   64     action[1:0] from_node[9:2] to_node[17:10]
//                       edge_capacity[47:18] source_node[55:48] sink_node[63:56]
// m (output) out 48     max_flow[47:0]
//
// clear: one matrix entry per cycle, 2^(2*clog2(MAX_NODES)) entries (65536 at 256)
// after reset the same clearing pass runs before the first transaction is taken
// add edge: read-modify-write of the reverse entry, then forward write
// compute: each search clears all visited marks, then does one matrix read per
//   node per dequeued node; a path hop reads the parent, then updates both entries
// s_tready is low outside idle; the result register lets a new transaction in
//   while the result waits, and a later compute holds in done until it drains
module max_flow_edmonds_karp_core
    import eka_pkg::*;
#(
    parameter int MAX_NODES = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,   // action, from_node, to_node, edge_capacity,
                                     // source_node, sink_node
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [47:0] o_m_tdata    // max_flow
);

    localparam int NW = $clog2(MAX_NODES);
    localparam int AW = 2 * NW;
    localparam int MDEPTH = 1 << AW;
    localparam int MW = FLOWW + 1;      // adjacency mark on top of residual
    localparam int QW = NW + CAPW;      // queue entry: node and bottleneck
    localparam logic [NW-1:0] LAST_NODE = NW'(MAX_NODES - 1);

    // input field split
    logic [ACTW-1:0]  in_act;
    logic [NODEW-1:0] in_from, in_to, in_src, in_snk;
    logic [CAPW-1:0]  in_cap;
    logic             s_acc;
    logic             edge_ok, comp_ok;

    assign in_act  = i_s_tdata[1:0];
    assign in_from = i_s_tdata[9:2];
    assign in_to   = i_s_tdata[17:10];
    assign in_cap  = i_s_tdata[47:18];
    assign in_src  = i_s_tdata[55:48];
    assign in_snk  = i_s_tdata[63:56];
    assign s_acc   = i_s_tvalid && o_s_tready;
    assign edge_ok = (32'(in_from) < MAX_NODES) && (32'(in_to) < MAX_NODES);
    assign comp_ok = (32'(in_src) < MAX_NODES) && (32'(in_snk) < MAX_NODES)
                     && (in_src != in_snk);

    // registers
    t_state           r_state, n_state;
    logic [AW-1:0]    r_clr_addr;
    logic [NW-1:0]    r_a, r_b, r_s, r_t, r_cur, r_prev, r_vd, r_sidx;
    logic [CAPW-1:0]  r_cap, r_bn, r_pbn;
    logic [FLOWW-1:0] r_flow;
    logic [NW:0]      r_head, r_tail, r_v, r_steps;
    logic             r_pv;
    logic             r_out_valid;
    logic [FLOWW-1:0] r_out_data;

    // memory ports
    logic            m_we, p_we, q_we, vis_we;
    logic [AW-1:0]   m_waddr, m_raddr;
    logic [MW-1:0]   m_wdata, m_rdata;
    logic [NW-1:0]   p_waddr, p_raddr, p_wdata, p_rdata;
    logic [NW-1:0]   q_waddr, q_raddr;
    logic [QW-1:0]   q_wdata, q_rdata;
    logic [NW-1:0]   vis_waddr, vis_raddr;
    logic            vis_wdata, vis_rdata;

    // graph matrix: {adjacent, residual}, address {row, column}
    eka_ram #(.WIDTH(MW), .DEPTH(MDEPTH)) u_graph (
        .i_clk(i_clk), .i_we(m_we), .i_waddr(m_waddr), .i_wdata(m_wdata),
        .i_raddr(m_raddr), .o_rdata(m_rdata)
    );

    // parent of each node found by the current search
    eka_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_parent (
        .i_clk(i_clk), .i_we(p_we), .i_waddr(p_waddr), .i_wdata(p_wdata),
        .i_raddr(p_raddr), .o_rdata(p_rdata)
    );

    // bfs queue
    eka_ram #(.WIDTH(QW), .DEPTH(MAX_NODES)) u_queue (
        .i_clk(i_clk), .i_we(q_we), .i_waddr(q_waddr), .i_wdata(q_wdata),
        .i_raddr(q_raddr), .o_rdata(q_rdata)
    );

    // visited marks of the current search, cleared at its start
    eka_ram #(.WIDTH(1), .DEPTH(MAX_NODES)) u_visited (
        .i_clk(i_clk), .i_we(vis_we), .i_waddr(vis_waddr), .i_wdata(vis_wdata),
        .i_raddr(vis_raddr), .o_rdata(vis_rdata)
    );

    // scan evaluation of the entry read last cycle
    logic [FLOWW-1:0] res;
    logic             hit, hit_dst, scan_last, q_room;
    logic [CAPW-1:0]  nb;
    logic [FLOWW:0]   flow_sum, rev_sum;
    logic [FLOWW-1:0] flow_sat, rev_sat;

    assign res       = m_rdata[FLOWW-1:0];
    assign hit       = r_pv && m_rdata[FLOWW] && !vis_rdata && (res != '0);
    assign nb        = (res < FLOWW'(r_bn)) ? res[CAPW-1:0] : r_bn;
    assign hit_dst   = hit && (r_vd == r_t);
    assign scan_last = r_pv && (r_vd == LAST_NODE);
    assign q_room    = 32'(r_tail) < MAX_NODES;
    assign flow_sum  = {1'b0, r_flow} + (FLOWW+1)'(nb);
    assign flow_sat  = flow_sum[FLOWW] ? FLOW_MAX : flow_sum[FLOWW-1:0];
    assign rev_sum   = {1'b0, res} + (FLOWW+1)'(r_pbn);
    assign rev_sat   = rev_sum[FLOWW] ? FLOW_MAX : rev_sum[FLOWW-1:0];

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLR: begin
                if (r_clr_addr == {AW{1'b1}}) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (s_acc) begin
                    case (in_act)
                        ACT_CLEAR:   n_state = S_CLR;
                        ACT_EDGE:    n_state = edge_ok ? S_EDGE_RMW : S_IDLE;
                        ACT_COMPUTE: n_state = comp_ok ? S_SRCH : S_DONE;
                        default:     n_state = S_IDLE;
                    endcase
                end
            end
            S_EDGE_RMW: n_state = S_EDGE_WR;
            S_EDGE_WR:  n_state = S_IDLE;
            S_SRCH:     n_state = (r_sidx == LAST_NODE) ? S_DEQ : S_SRCH;
            S_DEQ:      n_state = (r_head == r_tail) ? S_DONE : S_DEQW;
            S_DEQW:     n_state = S_SCAN;
            S_SCAN: begin
                if (hit_dst) n_state = S_APAR;
                else if (scan_last) n_state = S_DEQ;
            end
            S_APAR: begin
                if (r_cur == r_s || 32'(r_steps) == MAX_NODES) n_state = S_SRCH;
                else n_state = S_APARW;
            end
            S_APARW: n_state = S_AFWD;
            S_AFWD:  n_state = S_AREV;
            S_AREV:  n_state = S_APAR;
            S_DONE: begin
                if (!r_out_valid || i_m_tready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // memory controls
    always_comb begin
        m_we = 1'b0; m_waddr = '0; m_wdata = '0; m_raddr = '0;
        p_we = 1'b0; p_waddr = '0; p_wdata = '0; p_raddr = '0;
        q_we = 1'b0; q_waddr = '0; q_wdata = '0; q_raddr = '0;
        vis_we = 1'b0; vis_waddr = '0; vis_wdata = 1'b0; vis_raddr = '0;
        case (r_state)
            S_CLR: begin
                m_we = 1'b1;
                m_waddr = r_clr_addr;
            end
            S_IDLE: begin
                // reverse entry of a new edge, fetched for its residual
                m_raddr = {NW'(in_to), NW'(in_from)};
            end
            S_EDGE_RMW: begin
                m_we = 1'b1;
                m_waddr = {r_b, r_a};
                m_wdata = {1'b1, res};
            end
            S_EDGE_WR: begin
                m_we = 1'b1;
                m_waddr = {r_a, r_b};
                m_wdata = {1'b1, FLOWW'(r_cap)};
            end
            S_SRCH: begin
                // walk all marks, only the source starts visited
                vis_we = 1'b1; vis_waddr = r_sidx; vis_wdata = (r_sidx == r_s);
                p_we = 1'b1; p_waddr = r_s; p_wdata = r_s;
                q_we = 1'b1; q_waddr = '0; q_wdata = {r_s, BN_START};
            end
            S_DEQ: q_raddr = r_head[NW-1:0];
            S_SCAN: begin
                m_raddr = {r_cur, r_v[NW-1:0]};
                vis_raddr = r_v[NW-1:0];
                if (hit) begin
                    vis_we = 1'b1; vis_waddr = r_vd; vis_wdata = 1'b1;
                    p_we = 1'b1; p_waddr = r_vd; p_wdata = r_cur;
                    if (!hit_dst && q_room) begin
                        q_we = 1'b1; q_waddr = r_tail[NW-1:0]; q_wdata = {r_vd, nb};
                    end
                end
            end
            S_APAR:  p_raddr = r_cur;
            S_APARW: m_raddr = {p_rdata, r_cur};
            S_AFWD: begin
                m_we = 1'b1;
                m_waddr = {r_prev, r_cur};
                m_wdata = {m_rdata[FLOWW], res - FLOWW'(r_pbn)};
                m_raddr = {r_cur, r_prev};
            end
            S_AREV: begin
                m_we = 1'b1;
                m_waddr = {r_cur, r_prev};
                m_wdata = {m_rdata[FLOWW], rev_sat};
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr_addr <= '0;
            r_out_valid <= 1'b0;
            r_flow <= '0;
            r_pv <= 1'b0;
            r_sidx <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_DONE && (!r_out_valid || i_m_tready)) begin
                r_out_valid <= 1'b1;
            end else if (o_m_tvalid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLR: r_clr_addr <= r_clr_addr + 1'b1;
                S_IDLE: begin
                    r_clr_addr <= '0;
                    r_a <= NW'(in_from);
                    r_b <= NW'(in_to);
                    r_cap <= in_cap;
                    r_s <= NW'(in_src);
                    r_t <= NW'(in_snk);
                    r_flow <= '0;
                end
                S_SRCH: begin
                    r_sidx <= (r_sidx == LAST_NODE) ? '0 : r_sidx + 1'b1;
                    r_head <= '0;
                    r_tail <= (NW+1)'(1);
                end
                S_DEQW: begin
                    r_cur <= q_rdata[QW-1:CAPW];
                    r_bn <= q_rdata[CAPW-1:0];
                    r_head <= r_head + 1'b1;
                    r_v <= '0;
                    r_pv <= 1'b0;
                end
                S_SCAN: begin
                    r_pv <= 32'(r_v) < MAX_NODES;
                    r_vd <= r_v[NW-1:0];
                    r_v <= r_v + 1'b1;
                    if (hit) begin
                        if (hit_dst) begin
                            r_pbn <= nb;
                            r_flow <= flow_sat;
                            r_cur <= r_t;
                            r_steps <= '0;
                        end else if (q_room) begin
                            r_tail <= r_tail + 1'b1;
                        end
                    end
                end
                S_APARW: r_prev <= p_rdata;
                S_AREV: begin
                    r_cur <= r_prev;
                    r_steps <= r_steps + 1'b1;
                end
                S_DONE: begin
                    if (!r_out_valid || i_m_tready) begin
                        r_out_data <= r_flow;
                    end
                end
                default: ;
            endcase
        end
    end

    // a path hop never links a node to itself
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_AFWD) |-> (r_prev != r_cur))
        else $error("augment hop with equal ends");

    // queue never holds more entries than nodes
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN || r_state == S_DEQ) |-> (32'(r_tail) <= MAX_NODES))
        else $error("queue overrun");

    // head never passes tail
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DEQ) |-> (r_head <= r_tail))
        else $error("queue head beyond tail");

    // a result is only loaded from the done state
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("result outside done");

endmodule
